// ----- hw/rtl/stot_pkg.sv -----
// Shared constants and types for the sphere-triangle overlap test.
// Used by the multiplier, the lanes, the plane unit, the top level and the checker.
// Depends on nothing.
package stot_pkg;

   // Default coordinate width of the fixed-point vertices and center.
   localparam int COORD_BITS_DEFAULT = 16;

   // Limb width of the pipelined wide multiplier; partial products are at
   // most (LIMB+1) x (LIMB+1) bits.
   localparam int MUL_LIMB_BITS = 24;

   // Pipeline depth of the wide multiplier: partial products, row sums, final sum.
   localparam int MUL_LATENCY = 3;

   // Response data width: the overlap flag padded to a byte.
   localparam int RSP_TDATA_BITS = 8;

   // Register file addressing.
   localparam int CSR_INDEX_BITS = 2;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_CENTER_X = 2'd0;
   localparam csr_index_type CSR_CENTER_Y = 2'd1;
   localparam csr_index_type CSR_CENTER_Z = 2'd2;
   localparam csr_index_type CSR_RADIUS   = 2'd3;

endpackage

// ----- hw/rtl/stot_mul.sv -----
// Pipelined signed multiplier built from narrow limb products.
// Three register stages: partial products, row sums, final sum.
// Depends on stot_pkg for the limb width.
module stot_mul #(
   parameter int AW = 16,
   parameter int BW = 16
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [AW-1:0]    a,
   input  logic signed [BW-1:0]    b,
   output logic signed [AW+BW-1:0] p
);

   localparam int LW = stot_pkg::MUL_LIMB_BITS;
   localparam int NA = (AW + LW - 1) / LW;
   localparam int NB = (BW + LW - 1) / LW;
   localparam int PW = AW + BW;

   logic signed [NA*LW-1:0] ax;
   logic signed [NB*LW-1:0] bx;
   logic signed [LW:0]      al [NA];
   logic signed [LW:0]      bl [NB];
   logic signed [2*LW+1:0]  pp_ff [NA][NB];
   logic signed [PW-1:0]    row_c [NA];
   logic signed [PW-1:0]    row_ff [NA];
   logic signed [PW-1:0]    sum_c;
   logic signed [PW-1:0]    p_ff;

   assign ax = (NA*LW)'(a);
   assign bx = (NB*LW)'(b);

   // Lower limbs are unsigned, the top limb carries the sign.
   for (genvar i = 0; i < NA; i++) begin : g_al
      if (i == NA - 1) begin : g_top
         assign al[i] = {ax[NA*LW-1], ax[i*LW +: LW]};
      end else begin : g_low
         assign al[i] = {1'b0, ax[i*LW +: LW]};
      end
   end
   for (genvar j = 0; j < NB; j++) begin : g_bl
      if (j == NB - 1) begin : g_top
         assign bl[j] = {bx[NB*LW-1], bx[j*LW +: LW]};
      end else begin : g_low
         assign bl[j] = {1'b0, bx[j*LW +: LW]};
      end
   end

   // Stage one: every limb pair multiplied in parallel.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= al[i] * bl[j];
            end
         end
      end
   end

   // Stage two: one row per limb of a, modulo the product width.
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_c[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_c[i] = row_c[i] + (PW'(pp_ff[i][j]) <<< (j * LW));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         row_ff <= row_c;
      end
   end

   // Stage three: rows weighted and added.
   always_comb begin
      sum_c = '0;
      for (int i = 0; i < NA; i++) begin
         sum_c = sum_c + (row_ff[i] <<< (i * LW));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= sum_c;
      end
   end

   assign p = p_ff;

endmodule

// ----- hw/rtl/stot_lane.sv -----
// One vertex lane: the vertex-region test of vertex p and the edge-region
// test of the edge from p to q, with o the remaining vertex.
// Depends on stot_pkg and stot_mul.
module stot_lane #(
   parameter int COORD_BITS = stot_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [2*COORD_BITS-2:0] rr,
   input  logic signed [COORD_BITS:0]    p [3],
   input  logic signed [COORD_BITS:0]    q [3],
   input  logic signed [COORD_BITS:0]    o [3],
   output logic                          sep
);

   localparam int ML = stot_pkg::MUL_LATENCY;
   localparam int D  = COORD_BITS + 1;
   localparam int E  = COORD_BITS + 2;
   localparam int RR = 2 * COORD_BITS - 1;
   localparam int W1 = 2 * E + 2;
   localparam int W2 = W1 + E + 2;
   localparam int W3 = 2 * W2 + 2;
   localparam int KP = 2 + ML;
   localparam int KE = 1 + ML;
   localparam int KV = 2 + 2 * ML;
   localparam logic signed [W1-1:0] ZERO1 = '0;
   localparam logic signed [W3-1:0] ZERO3 = '0;

   logic signed [E-1:0]      side_ff [3];
   logic signed [E-1:0]      po_ff [3];
   logic signed [D-1:0]      p_dly_ff [KP][3];
   logic signed [D-1:0]      o_dly_ff [KP][3];
   logic signed [E-1:0]      side_dly_ff [KE][3];
   logic signed [2*D-1:0]    m_pp [3];
   logic signed [D+E-1:0]    m_ps [3];
   logic signed [D+E-1:0]    m_po [3];
   logic signed [2*E-1:0]    m_ss [3];
   logic signed [W1-1:0]     pp_ff, d_ff, dpo_ff, e_ff;
   logic                     vtx_c;
   logic [KV-1:0]            vtx_dly_ff;
   logic signed [D+W1-1:0]   m_pe [3];
   logic signed [D+W1-1:0]   m_oe [3];
   logic signed [W1+E-1:0]   m_ds [3];
   logic signed [2*W1-1:0]   m_ee;
   logic signed [W2-1:0]     q_ff [3];
   logic signed [W2-1:0]     qo_ff [3];
   logic signed [2*W1-1:0]   ee_ff;
   logic signed [2*W2-1:0]   m_qq [3];
   logic signed [2*W2-1:0]   m_qqo [3];
   logic signed [RR+2*W1-1:0] m_rree;
   logic signed [W3-1:0]     qq_ff, qqo_ff, rree_ff;
   logic                     sep_ff;

   // Edge vector and the vector toward the other vertex.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            side_ff[i] <= E'(q[i]) - E'(p[i]);
            po_ff[i]   <= E'(o[i]) - E'(p[i]);
         end
      end
   end

   // Operands waiting for the second multiply layer.
   always_ff @(posedge clock) begin
      if (en) begin
         p_dly_ff[0]    <= p;
         o_dly_ff[0]    <= o;
         side_dly_ff[0] <= side_ff;
         for (int k = 1; k < KP; k++) begin
            p_dly_ff[k] <= p_dly_ff[k-1];
            o_dly_ff[k] <= o_dly_ff[k-1];
         end
         for (int k = 1; k < KE; k++) begin
            side_dly_ff[k] <= side_dly_ff[k-1];
         end
      end
   end

   // First layer: p.p, p.edge, p.(o-p) and edge.edge.
   for (genvar i = 0; i < 3; i++) begin : g_l1
      stot_mul #(.AW(D), .BW(D)) u_pp (
         .clock(clock), .en(en), .a(p_dly_ff[0][i]), .b(p_dly_ff[0][i]), .p(m_pp[i]));
      stot_mul #(.AW(D), .BW(E)) u_ps (
         .clock(clock), .en(en), .a(p_dly_ff[0][i]), .b(side_ff[i]), .p(m_ps[i]));
      stot_mul #(.AW(D), .BW(E)) u_po (
         .clock(clock), .en(en), .a(p_dly_ff[0][i]), .b(po_ff[i]), .p(m_po[i]));
      stot_mul #(.AW(E), .BW(E)) u_ss (
         .clock(clock), .en(en), .a(side_ff[i]), .b(side_ff[i]), .p(m_ss[i]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff  <= W1'(m_pp[0]) + W1'(m_pp[1]) + W1'(m_pp[2]);
         d_ff   <= W1'(m_ps[0]) + W1'(m_ps[1]) + W1'(m_ps[2]);
         dpo_ff <= W1'(m_po[0]) + W1'(m_po[1]) + W1'(m_po[2]);
         e_ff   <= W1'(m_ss[0]) + W1'(m_ss[1]) + W1'(m_ss[2]);
      end
   end

   // Vertex region: outside the sphere and both edges pointing away.
   assign vtx_c = (pp_ff > W1'(rr)) && (d_ff > ZERO1) && (dpo_ff > ZERO1);

   always_ff @(posedge clock) begin
      if (en) begin
         vtx_dly_ff <= {vtx_dly_ff[KV-2:0], vtx_c};
      end
   end

   // Second layer: closest-point numerators scaled by the edge length squared.
   for (genvar i = 0; i < 3; i++) begin : g_l2
      stot_mul #(.AW(D), .BW(W1)) u_pe (
         .clock(clock), .en(en), .a(p_dly_ff[KP-1][i]), .b(e_ff), .p(m_pe[i]));
      stot_mul #(.AW(D), .BW(W1)) u_oe (
         .clock(clock), .en(en), .a(o_dly_ff[KP-1][i]), .b(e_ff), .p(m_oe[i]));
      stot_mul #(.AW(W1), .BW(E)) u_ds (
         .clock(clock), .en(en), .a(d_ff), .b(side_dly_ff[KE-1][i]), .p(m_ds[i]));
   end
   stot_mul #(.AW(W1), .BW(W1)) u_ee (
      .clock(clock), .en(en), .a(e_ff), .b(e_ff), .p(m_ee));

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            q_ff[i]  <= W2'(m_pe[i]) - W2'(m_ds[i]);
            qo_ff[i] <= W2'(m_oe[i]) - W2'(m_pe[i]) + W2'(m_ds[i]);
         end
         ee_ff <= m_ee;
      end
   end

   // Third layer: squared distance and direction toward the other vertex.
   for (genvar i = 0; i < 3; i++) begin : g_l3
      stot_mul #(.AW(W2), .BW(W2)) u_qq (
         .clock(clock), .en(en), .a(q_ff[i]), .b(q_ff[i]), .p(m_qq[i]));
      stot_mul #(.AW(W2), .BW(W2)) u_qqo (
         .clock(clock), .en(en), .a(q_ff[i]), .b(qo_ff[i]), .p(m_qqo[i]));
   end
   stot_mul #(.AW(RR), .BW(2*W1)) u_rree (
      .clock(clock), .en(en), .a(rr), .b(ee_ff), .p(m_rree));

   always_ff @(posedge clock) begin
      if (en) begin
         qq_ff   <= W3'(m_qq[0]) + W3'(m_qq[1]) + W3'(m_qq[2]);
         qqo_ff  <= W3'(m_qqo[0]) + W3'(m_qqo[1]) + W3'(m_qqo[2]);
         rree_ff <= W3'(m_rree);
      end
   end

   // Either region separates.
   always_ff @(posedge clock) begin
      if (en) begin
         sep_ff <= vtx_dly_ff[KV-1] | ((qq_ff > rree_ff) && (qqo_ff > ZERO3));
      end
   end

   assign sep = sep_ff;

endmodule

// ----- hw/rtl/stot_plane.sv -----
// Plane test: the sphere is separated when its center lies farther from the
// triangle plane than the radius. Degenerate triangles never separate here.
// Depends on stot_pkg and stot_mul.
module stot_plane #(
   parameter int COORD_BITS = stot_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [2*COORD_BITS-2:0] rr,
   input  logic signed [COORD_BITS:0]    a [3],
   input  logic signed [COORD_BITS:0]    b [3],
   input  logic signed [COORD_BITS:0]    c [3],
   output logic                          sep
);

   localparam int ML = stot_pkg::MUL_LATENCY;
   localparam int D  = COORD_BITS + 1;
   localparam int E  = COORD_BITS + 2;
   localparam int RR = 2 * COORD_BITS - 1;
   localparam int PV = 2 * E + 1;
   localparam int P2 = 2 * PV + 2;
   localparam int WC = 2 * P2;
   localparam int KA = 2 + ML;

   logic signed [E-1:0]       ab_ff [3];
   logic signed [E-1:0]       ac_ff [3];
   logic signed [D-1:0]       a_dly_ff [KA][3];
   logic signed [2*E-1:0]     m_x1 [3];
   logic signed [2*E-1:0]     m_x2 [3];
   logic signed [PV-1:0]      v_ff [3];
   logic signed [D+PV-1:0]    m_av [3];
   logic signed [2*PV-1:0]    m_vv [3];
   logic signed [P2-1:0]      d_ff, e_ff;
   logic signed [2*P2-1:0]    m_dd;
   logic signed [RR+P2-1:0]   m_re;
   logic                      cmp_ff;
   logic                      sep_ff;

   // Edges from vertex a toward vertices b and c.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            ab_ff[i] <= E'(b[i]) - E'(a[i]);
            ac_ff[i] <= E'(c[i]) - E'(a[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_dly_ff[0] <= a;
         for (int k = 1; k < KA; k++) begin
            a_dly_ff[k] <= a_dly_ff[k-1];
         end
      end
   end

   // Cross product of the edges ab and ac gives the plane normal.
   for (genvar i = 0; i < 3; i++) begin : g_cross
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      stot_mul #(.AW(E), .BW(E)) u_x1 (
         .clock(clock), .en(en), .a(ab_ff[J]), .b(ac_ff[K]), .p(m_x1[i]));
      stot_mul #(.AW(E), .BW(E)) u_x2 (
         .clock(clock), .en(en), .a(ab_ff[K]), .b(ac_ff[J]), .p(m_x2[i]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            v_ff[i] <= PV'(m_x1[i]) - PV'(m_x2[i]);
         end
      end
   end

   // Distance numerator a.v and normal length squared v.v.
   for (genvar i = 0; i < 3; i++) begin : g_dot
      stot_mul #(.AW(D), .BW(PV)) u_av (
         .clock(clock), .en(en), .a(a_dly_ff[KA-1][i]), .b(v_ff[i]), .p(m_av[i]));
      stot_mul #(.AW(PV), .BW(PV)) u_vv (
         .clock(clock), .en(en), .a(v_ff[i]), .b(v_ff[i]), .p(m_vv[i]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= P2'(m_av[0]) + P2'(m_av[1]) + P2'(m_av[2]);
         e_ff <= P2'(m_vv[0]) + P2'(m_vv[1]) + P2'(m_vv[2]);
      end
   end

   // Compare d*d against r*r*e without any division.
   stot_mul #(.AW(P2), .BW(P2)) u_dd (
      .clock(clock), .en(en), .a(d_ff), .b(d_ff), .p(m_dd));
   stot_mul #(.AW(RR), .BW(P2)) u_re (
      .clock(clock), .en(en), .a(rr), .b(e_ff), .p(m_re));

   always_ff @(posedge clock) begin
      if (en) begin
         cmp_ff <= m_dd > WC'(m_re);
         sep_ff <= cmp_ff;
      end
   end

   assign sep = sep_ff;

endmodule

// ----- hw/rtl/sphere_triangle_overlap_test.sv -----
// Sphere-triangle overlap test, top level.
//
// Requests on req_ carry one triangle (three vertices) each; one response on
// rsp_ follows for every request, in order, with the overlap flag (touching
// counts as overlap). The query sphere (center and radius) is written through
// csr_, which is always ready; write it only while no request is in flight.
//
// The vertices are moved into sphere-centered coordinates, then three vertex
// lanes (vertex region plus the edge leaving that vertex) and a plane unit
// run side by side; a merge stage ORs their separation flags.
//
// Throughput: one request per cycle unless a response is stalled.
// The depth from request acceptance to rsp_tvalid is set by three chained
// layers of limb-split multipliers.
// A waiting response with rsp_tready low freezes the whole pipeline and drops
// req_tready in the same cycle; the response register holds until taken.
// Synchronous reset empties the pipeline and clears the sphere to a point at
// the origin; the radius square becomes valid in the cycle after reset.
// Depends on stot_pkg, stot_mul, stot_lane and stot_plane.
module sphere_triangle_overlap_test #(
   parameter int COORD_BITS = stot_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
   // vertex_c_x, vertex_c_y, vertex_c_z, then zero padding
   input  logic [((9*COORD_BITS+7)/8)*8-1:0]         req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // overlaps, then zero padding
   output logic [stot_pkg::RSP_TDATA_BITS-1:0]       rsp_tdata,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  stot_pkg::csr_index_type                   csr_index,
   input  logic [COORD_BITS-1:0]                     csr_data
);

   localparam int N    = COORD_BITS;
   localparam int D    = N + 1;
   localparam int RR   = 2 * N - 1;
   localparam int NSTG = 7 + 3 * stot_pkg::MUL_LATENCY;

   logic signed [N-1:0]   cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;
   logic [N-2:0]          r_ff, r_in;
   logic [2*N-3:0]        r_sq;
   logic signed [RR-1:0]  rr_ff;
   logic signed [N-1:0]   ctr [3];
   logic signed [D-1:0]   va_ff [3];
   logic signed [D-1:0]   vb_ff [3];
   logic signed [D-1:0]   vc_ff [3];
   logic [NSTG-1:0]       vld_ff;
   logic                  en;
   logic                  plane_sep;
   logic [2:0]            lane_sep;
   logic                  ovl_ff;

   // Configuration registers.
   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      r_in  = r_ff;
      if (csr_valid) begin
         unique case (csr_index)
            stot_pkg::CSR_CENTER_X: cx_in = csr_data;
            stot_pkg::CSR_CENTER_Y: cy_in = csr_data;
            stot_pkg::CSR_CENTER_Z: cz_in = csr_data;
            stot_pkg::CSR_RADIUS:   r_in  = csr_data[N-2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
         cz_ff <= '0;
         r_ff  <= '0;
      end else begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
         r_ff  <= r_in;
      end
   end

   assign csr_ready = 1'b1;

   // Radius squared; only the user keeps it constant while requests flow.
   assign r_sq = (2*N-2)'(r_ff) * (2*N-2)'(r_ff);

   always_ff @(posedge clock) begin
      rr_ff <= {1'b0, r_sq};
   end

   // The whole pipeline advances unless the response register is stuck.
   assign en         = !vld_ff[NSTG-1] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_tvalid};
      end
   end

   assign ctr[0] = cx_ff;
   assign ctr[1] = cy_ff;
   assign ctr[2] = cz_ff;

   // Move the vertices into sphere-centered coordinates.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            va_ff[i] <= D'($signed(req_tdata[i*N +: N])) - D'(ctr[i]);
            vb_ff[i] <= D'($signed(req_tdata[(3+i)*N +: N])) - D'(ctr[i]);
            vc_ff[i] <= D'($signed(req_tdata[(6+i)*N +: N])) - D'(ctr[i]);
         end
      end
   end

   stot_plane #(.COORD_BITS(COORD_BITS)) u_plane (
      .clock(clock), .en(en), .rr(rr_ff),
      .a(va_ff), .b(vb_ff), .c(vc_ff), .sep(plane_sep));

   stot_lane #(.COORD_BITS(COORD_BITS)) u_lane_a (
      .clock(clock), .en(en), .rr(rr_ff),
      .p(va_ff), .q(vb_ff), .o(vc_ff), .sep(lane_sep[0]));

   stot_lane #(.COORD_BITS(COORD_BITS)) u_lane_b (
      .clock(clock), .en(en), .rr(rr_ff),
      .p(vb_ff), .q(vc_ff), .o(va_ff), .sep(lane_sep[1]));

   stot_lane #(.COORD_BITS(COORD_BITS)) u_lane_c (
      .clock(clock), .en(en), .rr(rr_ff),
      .p(vc_ff), .q(va_ff), .o(vb_ff), .sep(lane_sep[2]));

   // Merge: overlap only when no test separates.
   always_ff @(posedge clock) begin
      if (en) begin
         ovl_ff <= !(plane_sep || (|lane_sep));
      end
   end

   assign rsp_tvalid = vld_ff[NSTG-1];
   assign rsp_tdata  = {{(stot_pkg::RSP_TDATA_BITS-1){1'b0}}, ovl_ff};

endmodule

// ----- hw/rtl/stot_checker.sv -----
// Port-level checks for the sphere-triangle overlap test, bound to the top level.
// Depends on stot_pkg and sphere_triangle_overlap_test.
module stot_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [stot_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // The pipeline takes a request exactly when the output can move.
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready does not follow the output stage");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // Only the overlap bit is ever set.
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[stot_pkg::RSP_TDATA_BITS-1:1] == '0)
      else $error("response padding not zero");

endmodule

bind sphere_triangle_overlap_test stot_checker u_stot_checker (.*);

// ----- tb/sv/tb_sphere_triangle_overlap_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sphere-triangle overlap test block.
// Needs stot_pkg and the RTL of sphere_triangle_overlap_test; predicts every
// overlap flag with exact wide integer arithmetic and checks it in order.
module tb_sphere_triangle_overlap_test;
   import stot_pkg::*;

   localparam int CB = 16;
   localparam int REQ_BITS = ((9*CB+7)/8)*8;
   localparam int LATENCY = 7 + 3 * MUL_LATENCY;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef logic signed [255:0] wide_t;
   typedef logic [CB-1:0] coord_t;
   typedef struct packed {
      coord_t cz, cy, cx, bz, by, bx, az, ay, ax;
   } triangle_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_CENTER_X;
   logic [CB-1:0] csr_data = '0;

   sphere_triangle_overlap_test #(.COORD_BITS(CB)) uut (.*);

   // Predictor copy of the sphere registers.
   logic signed [CB-1:0] sph_x = '0, sph_y = '0, sph_z = '0;
   logic [CB-2:0] sph_r = '0;

   triangle_t pending_triangles[$];
   bit expected_overlaps[$];
   int errors = 0;
   int triangles_sent = 0;
   int overlaps_seen = 0;
   int responses_seen = 0;
   bit idle_free = 1'b0;
   int req_gap = 0;
   int hold_count = 0;
   bit hold_done = 1'b0;
   int quiet_cycles = 0;

   initial forever #4 clock = ~clock;

   function automatic wide_t dot(wide_t ax, wide_t ay, wide_t az,
                                 wide_t bx, wide_t by, wide_t bz);
      return ax * bx + ay * by + az * bz;
   endfunction

   // Edge region: the point of the edge line nearest the center, scaled by e,
   // lies outside the sphere and on the far side from the opposite vertex.
   function automatic bit edge_separates(wide_t p[3], wide_t o[3], wide_t ed[3],
                                         wide_t d, wide_t e, wide_t rr);
      wide_t q[3], qo[3];
      for (int i = 0; i < 3; i++) begin
         q[i] = p[i] * e - d * ed[i];
         qo[i] = o[i] * e - q[i];
      end
      return (dot(q[0], q[1], q[2], q[0], q[1], q[2]) > rr * e * e) &&
             (dot(q[0], q[1], q[2], qo[0], qo[1], qo[2]) > 0);
   endfunction

   function automatic bit predict_overlap(triangle_t t);
      wide_t a[3], b[3], c[3], eab[3], ebc[3], eca[3], eac[3], v[3];
      wide_t rr, d, e, aa, ab, ac, bb, bc, cc;
      bit sep;
      a[0] = wide_t'($signed(t.ax)) - wide_t'(sph_x);
      a[1] = wide_t'($signed(t.ay)) - wide_t'(sph_y);
      a[2] = wide_t'($signed(t.az)) - wide_t'(sph_z);
      b[0] = wide_t'($signed(t.bx)) - wide_t'(sph_x);
      b[1] = wide_t'($signed(t.by)) - wide_t'(sph_y);
      b[2] = wide_t'($signed(t.bz)) - wide_t'(sph_z);
      c[0] = wide_t'($signed(t.cx)) - wide_t'(sph_x);
      c[1] = wide_t'($signed(t.cy)) - wide_t'(sph_y);
      c[2] = wide_t'($signed(t.cz)) - wide_t'(sph_z);
      rr = wide_t'({1'b0, sph_r}) * wide_t'({1'b0, sph_r});
      for (int i = 0; i < 3; i++) begin
         eab[i] = b[i] - a[i];
         ebc[i] = c[i] - b[i];
         eca[i] = a[i] - c[i];
         eac[i] = c[i] - a[i];
      end
      // Plane of the triangle.
      v[0] = eab[1] * eac[2] - eab[2] * eac[1];
      v[1] = eab[2] * eac[0] - eab[0] * eac[2];
      v[2] = eab[0] * eac[1] - eab[1] * eac[0];
      d = dot(a[0], a[1], a[2], v[0], v[1], v[2]);
      e = dot(v[0], v[1], v[2], v[0], v[1], v[2]);
      sep = d * d > rr * e;
      // Vertex regions.
      aa = dot(a[0], a[1], a[2], a[0], a[1], a[2]);
      ab = dot(a[0], a[1], a[2], b[0], b[1], b[2]);
      ac = dot(a[0], a[1], a[2], c[0], c[1], c[2]);
      bb = dot(b[0], b[1], b[2], b[0], b[1], b[2]);
      bc = dot(b[0], b[1], b[2], c[0], c[1], c[2]);
      cc = dot(c[0], c[1], c[2], c[0], c[1], c[2]);
      sep |= (aa > rr) && (ab > aa) && (ac > aa);
      sep |= (bb > rr) && (ab > bb) && (bc > bb);
      sep |= (cc > rr) && (ac > cc) && (bc > cc);
      // Edge regions.
      sep |= edge_separates(a, c, eab, ab - aa,
                            dot(eab[0], eab[1], eab[2], eab[0], eab[1], eab[2]), rr);
      sep |= edge_separates(b, a, ebc, bc - bb,
                            dot(ebc[0], ebc[1], ebc[2], ebc[0], ebc[1], ebc[2]), rr);
      sep |= edge_separates(c, b, eca, ac - cc,
                            dot(eca[0], eca[1], eca[2], eca[0], eca[1], eca[2]), rr);
      return !sep;
   endfunction

   // Request driver: pops pending triangles with random gaps between them.
   always @(posedge clock) begin
      int roll;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_triangles.size() > 0) begin
            req_tdata <= REQ_BITS'(pending_triangles.pop_front());
            req_tvalid <= 1'b1;
            roll = $urandom_range(0, 99);
            if (idle_free || roll < 60) req_gap <= 0;
            else if (roll < 92) req_gap <= $urandom_range(1, 3);
            else req_gap <= $urandom_range(10, 40);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response acceptor: random stalls, plus one long hold-off while requests keep coming.
   always @(posedge clock) begin
      int roll;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && triangles_sent >= 400) begin
         hold_done <= 1'b1;
         hold_count <= 300;
         rsp_tready <= 1'b0;
      end else begin
         roll = $urandom_range(0, 99);
         if (idle_free || roll < 70) rsp_tready <= 1'b1;
         else if (roll < 97) rsp_tready <= 1'b0;
         else begin
            rsp_tready <= 1'b0;
            hold_count <= $urandom_range(10, 40);
         end
      end
   end

   // Monitor: tracks register writes, predicts accepted requests, checks responses.
   always @(posedge clock) begin
      bit want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CENTER_X: sph_x <= csr_data;
               CSR_CENTER_Y: sph_y <= csr_data;
               CSR_CENTER_Z: sph_z <= csr_data;
               CSR_RADIUS:   sph_r <= csr_data[CB-2:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_overlaps.push_back(predict_overlap(triangle_t'(req_tdata[9*CB-1:0])));
            triangles_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            responses_seen++;
            if (expected_overlaps.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               want = expected_overlaps.pop_front();
               if (rsp_tdata[0] !== want) begin
                  $error("overlaps mismatch: expected %0d, actual %0d", want, rsp_tdata[0]);
                  errors++;
               end
               overlaps_seen += want;
            end
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [CB-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_sphere(int x, int y, int z, int r);
      write_reg(CSR_CENTER_X, CB'(x));
      write_reg(CSR_CENTER_Y, CB'(y));
      write_reg(CSR_CENTER_Z, CB'(z));
      write_reg(CSR_RADIUS, CB'(r));
      csr_valid <= 1'b0;
   endtask

   function automatic triangle_t make_triangle(int v[9]);
      triangle_t t;
      t.ax = CB'(v[0]); t.ay = CB'(v[1]); t.az = CB'(v[2]);
      t.bx = CB'(v[3]); t.by = CB'(v[4]); t.bz = CB'(v[5]);
      t.cx = CB'(v[6]); t.cy = CB'(v[7]); t.cz = CB'(v[8]);
      return t;
   endfunction

   // Mostly triangles scattered around the sphere, some fully random.
   task automatic queue_random(int count, int x, int y, int z, int r);
      int v[9];
      int span;
      triangle_t t;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 25) begin
            t = triangle_t'((9*CB)'({$urandom, $urandom, $urandom, $urandom, $urandom}));
         end else begin
            span = 2 * r + 64;
            if ($urandom_range(0, 3) == 0) span = span / 4 + 8;
            for (int k = 0; k < 9; k++)
               v[k] = ((k % 3 == 0) ? x : (k % 3 == 1) ? y : z) +
                      $signed($urandom_range(0, 2 * span)) - span;
            t = make_triangle(v);
         end
         pending_triangles.push_back(t);
      end
   endtask

   task automatic drain;
      while (pending_triangles.size() > 0 || req_tvalid || expected_overlaps.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   initial begin
      int px, py, pz, pr;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed cases against the reset sphere, a point at the origin.
      pending_triangles.push_back(make_triangle('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
      pending_triangles.push_back(make_triangle('{0, 0, 0, 5, 0, 0, 0, 5, 0}));
      pending_triangles.push_back(make_triangle('{-5, 0, 0, 5, 0, 0, 9, 0, 0}));
      pending_triangles.push_back(make_triangle('{1, 1, 0, 1, 1, 0, 3, 3, 0}));
      pending_triangles.push_back(make_triangle('{-32768, -32768, -32768, 32767, 32767,
                                                  32767, -32768, 32767, 0}));
      pending_triangles.push_back(make_triangle('{32767, 32767, 32767, 32767, 32767,
                                                  32767, 32767, 32767, 32767}));
      pending_triangles.push_back(make_triangle('{-32768, -32768, -32768, -32768,
                                                  -32768, -32768, -32768, -32768, -32768}));
      pending_triangles.push_back(make_triangle('{-10, -10, 1, 10, -10, 1, 0, 10, 1}));
      pending_triangles.push_back(make_triangle('{-10, -10, 0, 10, -10, 0, 0, 10, 0}));
      drain();

      // Sphere of radius 100: touching the plane, a vertex and an edge exactly.
      set_sphere(0, 0, 0, 100);
      pending_triangles.push_back(make_triangle('{-500, -500, 100, 500, -500, 100, 0, 500, 100}));
      pending_triangles.push_back(make_triangle('{-500, -500, 101, 500, -500, 101, 0, 500, 101}));
      pending_triangles.push_back(make_triangle('{100, 0, 0, 300, 0, 0, 300, 50, 0}));
      pending_triangles.push_back(make_triangle('{101, 0, 0, 300, 0, 0, 300, 50, 0}));
      pending_triangles.push_back(make_triangle('{-50, 100, 0, 50, 100, 0, 0, 300, 0}));
      pending_triangles.push_back(make_triangle('{-50, 101, 0, 50, 101, 0, 0, 300, 0}));
      pending_triangles.push_back(make_triangle('{200, 0, 0, 200, 0, 0, 200, 0, 0}));
      pending_triangles.push_back(make_triangle('{-300, 0, 0, 300, 0, 0, 900, 0, 0}));
      pending_triangles.push_back(make_triangle('{-300, 100, 0, 300, 100, 0, 300, 100, 0}));
      drain();

      // Extreme spheres, then random ones; the last phase runs without idling.
      set_sphere(-32768, -32768, -32768, 32767);
      queue_random(150, -32768, -32768, -32768, 32767);
      drain();
      set_sphere(32767, 32767, 32767, 0);
      queue_random(150, 32767, 32767, 32767, 0);
      drain();
      for (int ph = 0; ph < 5; ph++) begin
         px = $signed($urandom_range(0, 65535)) - 32768;
         py = $signed($urandom_range(0, 65535)) - 32768;
         pz = $signed($urandom_range(0, 65535)) - 32768;
         pr = (ph == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 3000);
         idle_free = (ph == 4);
         set_sphere(px, py, pz, pr);
         queue_random(150, px, py, pz, pr);
         drain();
      end

      errors += expected_overlaps.size();
      $display("Checked %0d triangles (%0d overlapping) over nine sphere settings,",
               responses_seen, overlaps_seen);
      $display("including extreme registers, touching cases and a long output stall.");
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- sphere_triangle_overlap_test.f -----
hw/rtl/stot_pkg.sv
hw/rtl/stot_mul.sv
hw/rtl/stot_lane.sv
hw/rtl/stot_plane.sv
hw/rtl/sphere_triangle_overlap_test.sv
hw/rtl/stot_checker.sv
tb/sv/tb_sphere_triangle_overlap_test.sv
